FILE: sv/crp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_pkg
// Types, constants and arithmetic helpers for the Catmull-Rom path follower.
// ----------------------------------------------------------------------------
package crp_pkg;

    localparam int MAX_POINTS = 8;
    localparam int PT_IDX_W   = $clog2(MAX_POINTS);
    localparam int COORD_W    = 16;
    localparam int ACC_W      = 22;          // horner accumulator
    localparam int T_W        = 17;          // curve parameter, Q1.16
    localparam int MUL_CNT_W  = $clog2(T_W); // serial multiplier bit counter
    localparam int CNT_W      = 4;           // point count register
    localparam int RATE_W     = 16;
    localparam int DT_W       = 16;
    localparam int CFG_W      = 16;

    localparam logic [T_W-1:0]   T_ONE      = T_W'(65536);
    localparam logic [RATE_W-1:0] RATE_RST  = RATE_W'(256);
    localparam logic [CNT_W-1:0] CNT_RST    = CNT_W'(8);
    localparam logic [CNT_W-1:0] CNT_MIN    = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_POINTS);

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_type;

    typedef enum logic {
        CFG_RATE  = 1'b0,
        CFG_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_req_type                   req_type;
        logic [2:0]                  point_index;
        logic signed [COORD_W-1:0]   point_x;
        logic signed [COORD_W-1:0]   point_y;
        logic signed [COORD_W-1:0]   point_z;
        logic [DT_W-1:0]             tick_dt;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0]   pos_x;
        logic signed [COORD_W-1:0]   pos_y;
        logic signed [COORD_W-1:0]   pos_z;
        logic                        in_flight;
        logic                        path_done;
        logic [2:0]                  segment_now;
    } t_out;

    typedef struct packed {
        logic signed [COORD_W-1:0]   x;
        logic signed [COORD_W-1:0]   y;
        logic signed [COORD_W-1:0]   z;
    } t_point;

    typedef struct packed {
        logic                        start;
        logic signed [ACC_W-1:0]     mcand;
        logic [T_W-1:0]              mplier;
    } t_mul_req;

    typedef struct packed {
        logic                        busy;
        logic                        done;
        logic signed [ACC_W-1:0]     hi;
        logic [T_W-1:0]              lo;
    } t_mul_res;

    typedef struct packed {
        logic signed [ACC_W-1:0]     a0;
        logic signed [ACC_W-1:0]     a1;
        logic signed [ACC_W-1:0]     a2;
        logic signed [ACC_W-1:0]     a3;
    } t_coef;

    function automatic logic signed [ACC_W-1:0] sx(input logic signed [COORD_W-1:0] v);
        return {{(ACC_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic t_coef crp_coef(input logic signed [COORD_W-1:0] q0,
                                       input logic signed [COORD_W-1:0] q1,
                                       input logic signed [COORD_W-1:0] q2,
                                       input logic signed [COORD_W-1:0] q3);
        t_coef c;
        logic signed [ACC_W-1:0] e0, e1, e2, e3;
        e0 = sx(q0);
        e1 = sx(q1);
        e2 = sx(q2);
        e3 = sx(q3);
        c.a0 = e1 <<< 1;
        c.a1 = e2 - e0;
        c.a2 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        c.a3 = e1 + (e1 <<< 1) - e0 - e2 - (e2 <<< 1) + e3;
        return c;
    endfunction

    function automatic logic [CNT_W-1:0] clamp_idx(input logic [CNT_W-1:0] i,
                                                   input logic [CNT_W-1:0] n);
        return (i > n - CNT_W'(1)) ? n - CNT_W'(1) : i;
    endfunction

    // round half up, then saturate to the coordinate range
    function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] p);
        logic signed [ACC_W-1:0] v;
        v = (p + ACC_W'(1)) >>> 1;
        if (v > sx({1'b0, {(COORD_W-1){1'b1}}}))
            return {1'b0, {(COORD_W-1){1'b1}}};
        else if (v < sx({1'b1, {(COORD_W-1){1'b0}}}))
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

FILE: sv/crp_ser_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_ser_mul
// Radix-2 shift-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, product bits shifted out low end first.
// ----------------------------------------------------------------------------
module crp_ser_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  crp_pkg::t_mul_req i_req,
    output crp_pkg::t_mul_res o_res
);
    import crp_pkg::*;

    logic                    r_run;
    logic                    r_done;
    logic [MUL_CNT_W-1:0]    r_cnt;
    logic signed [ACC_W-1:0] r_m;
    logic signed [ACC_W-1:0] r_acc;
    logic [T_W-1:0]          r_b;
    logic [T_W-1:0]          r_lo;
    logic signed [ACC_W:0]   sum;

    always_comb begin
        sum = {r_acc[ACC_W-1], r_acc} + (r_b[0] ? {r_m[ACC_W-1], r_m} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && (r_cnt == MUL_CNT_W'(T_W - 1));
            if (r_run) begin
                r_cnt <= r_cnt + MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(T_W - 1)) begin
                    r_run <= 1'b0;
                end
            end else if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_run) begin
            r_acc <= sum[ACC_W:1];
            r_lo  <= {sum[0], r_lo[T_W-1:1]};
            r_b   <= r_b >> 1;
        end else if (i_req.start) begin
            r_m   <= i_req.mcand;
            r_b   <= i_req.mplier;
            r_acc <= '0;
        end
    end

    assign o_res.busy = r_run;
    assign o_res.done = r_done;
    assign o_res.hi   = r_acc;
    assign o_res.lo   = r_lo;

endmodule

FILE: sv/crp_pt_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_pt_store
// Control point memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module crp_pt_store (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [crp_pkg::PT_IDX_W-1:0]    i_waddr,
    input  crp_pkg::t_point                 i_wdata,
    input  logic [crp_pkg::PT_IDX_W-1:0]    i_raddr,
    output crp_pkg::t_point                 o_rdata
);
    import crp_pkg::*;

    t_point r_mem [MAX_POINTS];
    t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/catmull_rom_path_follower.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_path_follower
// Moves a point along a stored path by uniform Catmull-Rom interpolation.
// ----------------------------------------------------------------------------
// write, start and idle ticks give their result in the cycle after the request;
// a flying tick runs the increment multiply, the point fetch, then for each
// coordinate a load and three serial multiplies, then a final output step,
// using the one bit-serial multiplier shared by all products
// one request at a time; the result strobe lasts one cycle and cannot be held
// synchronous active-low reset: flight state cleared, registers to defaults,
// point memory not cleared
module catmull_rom_path_follower (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  crp_pkg::t_in            i_req,
    output logic                    o_valid,
    output crp_pkg::t_out           o_res,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_addr,
    input  logic [crp_pkg::CFG_W-1:0] i_cfg_wdata
);
    import crp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INC   = 6'b000010,
        S_FETCH = 6'b000100,
        S_LOAD  = 6'b001000,
        S_MUL   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [RATE_W-1:0]       r_rate;
    logic [CNT_W-1:0]        r_cnt;
    logic [T_W-1:0]          r_t, n_t;
    logic [2:0]              r_seg;
    logic                    r_fly;
    logic                    r_valid;
    t_out                    r_out;
    logic [2:0]              r_fk;
    logic [1:0]              r_step;
    logic [1:0]              r_coord;
    logic signed [ACC_W-1:0] r_p;
    t_point                  r_q [4];
    logic signed [COORD_W-1:0] r_pos [3];

    logic                    accept;
    t_mul_req                mul_req;
    t_mul_res                mul_res;
    t_point                  rd_pt;
    logic [PT_IDX_W-1:0]     raddr;
    logic [CNT_W-1:0]        n_pts;
    logic [CNT_W-1:0]        seg_ext;
    logic [CNT_W-1:0]        idx [4];
    logic [2:0]              fk_prev;
    logic signed [COORD_W-1:0] q [4];
    t_coef                   coef;
    logic signed [ACC_W-1:0] addc;
    logic signed [ACC_W:0]   prodq;
    logic signed [ACC_W-1:0] p_new;
    logic [30:0]             inc;
    logic [30:0]             tsum;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // clamped point count and neighbour indices
    always_comb begin
        n_pts = r_cnt;
        if (r_cnt < CNT_MIN) n_pts = CNT_MIN;
        if (r_cnt > CNT_MAX) n_pts = CNT_MAX;
        seg_ext = {1'b0, r_seg};
        idx[0] = clamp_idx((r_seg == 3'd0) ? '0 : seg_ext - CNT_W'(1), n_pts);
        idx[1] = clamp_idx(seg_ext, n_pts);
        idx[2] = clamp_idx(seg_ext + CNT_W'(1), n_pts);
        idx[3] = clamp_idx(seg_ext + CNT_W'(2), n_pts);
        raddr  = idx[r_fk[1:0]][PT_IDX_W-1:0];
        fk_prev = r_fk - 3'd1;
    end

    // coordinate slice for the current axis
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            case (r_coord)
                2'd0:    q[k] = r_q[k].x;
                2'd1:    q[k] = r_q[k].y;
                default: q[k] = r_q[k].z;
            endcase
        end
        coef = crp_coef(q[0], q[1], q[2], q[3]);
        case (r_step)
            2'd0:    addc = coef.a2;
            2'd1:    addc = coef.a1;
            default: addc = coef.a0;
        endcase
        // floor(p*t / 2^16) from the serial product
        prodq = {mul_res.hi, mul_res.lo[T_W-1]};
        p_new = ACC_W'(prodq + {addc[ACC_W-1], addc});
    end

    // increment and saturated parameter
    always_comb begin
        inc  = {mul_res.hi[ACC_W-1:0], mul_res.lo[T_W-1:8]};
        tsum = {14'd0, r_t} + inc;
        n_t  = (tsum > {14'd0, T_ONE}) ? T_ONE : tsum[T_W-1:0];
    end

    always_comb begin
        mul_req.start  = 1'b0;
        mul_req.mcand  = r_p;
        mul_req.mplier = r_t;
        if (accept && i_req.req_type == REQ_TICK && r_fly) begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = ACC_W'(r_rate);
            mul_req.mplier = T_W'(i_req.tick_dt);
        end else if (r_state == S_LOAD) begin
            mul_req.start = 1'b1;
            mul_req.mcand = coef.a3;
        end else if (r_state == S_MUL && mul_res.done && r_step != 2'd2) begin
            mul_req.start = 1'b1;
            mul_req.mcand = p_new;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && i_req.req_type == REQ_TICK && r_fly) n_state = S_INC;
            S_INC:   if (mul_res.done) n_state = S_FETCH;
            S_FETCH: if (r_fk == 3'd4) n_state = S_LOAD;
            S_LOAD:  n_state = S_MUL;
            S_MUL:   begin
                if (mul_res.done && r_step == 2'd2)
                    n_state = (r_coord == 2'd2) ? S_FIN : S_LOAD;
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rate  <= RATE_RST;
            r_cnt   <= CNT_RST;
            r_t     <= '0;
            r_seg   <= '0;
            r_fly   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (accept && !(i_req.req_type == REQ_TICK && r_fly)) ||
                       (r_state == S_FIN);
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_RATE:  r_rate <= i_cfg_wdata[RATE_W-1:0];
                    CFG_COUNT: r_cnt  <= i_cfg_wdata[CNT_W-1:0];
                    default:   ;
                endcase
            end
            if (accept && i_req.req_type == REQ_START) begin
                r_seg <= '0;
                r_t   <= '0;
                r_fly <= 1'b1;
            end
            if (r_state == S_INC && mul_res.done) begin
                r_t <= n_t;
            end
            if (r_state == S_FIN) begin
                if (r_t >= T_ONE) begin
                    if (seg_ext >= n_pts - CNT_W'(3)) begin
                        r_fly <= 1'b0;
                    end else begin
                        r_seg <= r_seg + 3'd1;
                        r_t   <= '0;
                    end
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.pos_x       <= '0;
            r_out.pos_y       <= '0;
            r_out.pos_z       <= '0;
            r_out.path_done   <= 1'b0;
            r_out.in_flight   <= r_fly || (i_req.req_type == REQ_START);
            r_out.segment_now <= (i_req.req_type == REQ_START) ? 3'd0 : r_seg;
        end
        if (r_state == S_INC) begin
            r_fk <= '0;
        end
        if (r_state == S_FETCH) begin
            r_fk <= r_fk + 3'd1;
            if (r_fk != 3'd0) r_q[fk_prev[1:0]] <= rd_pt;
            r_coord <= '0;
        end
        if (r_state == S_LOAD) begin
            r_p    <= coef.a3;
            r_step <= '0;
        end
        if (r_state == S_MUL && mul_res.done) begin
            if (r_step == 2'd2) begin
                r_pos[r_coord] <= round_sat(p_new);
                r_coord        <= r_coord + 2'd1;
            end else begin
                r_p    <= p_new;
                r_step <= r_step + 2'd1;
            end
        end
        if (r_state == S_FIN) begin
            r_out.pos_x <= r_pos[0];
            r_out.pos_y <= r_pos[1];
            r_out.pos_z <= r_pos[2];
            if (r_t >= T_ONE) begin
                if (seg_ext >= n_pts - CNT_W'(3)) begin
                    r_out.in_flight   <= 1'b0;
                    r_out.path_done   <= 1'b1;
                    r_out.segment_now <= r_seg;
                end else begin
                    r_out.in_flight   <= 1'b1;
                    r_out.path_done   <= 1'b0;
                    r_out.segment_now <= r_seg + 3'd1;
                end
            end else begin
                r_out.in_flight   <= 1'b1;
                r_out.path_done   <= 1'b0;
                r_out.segment_now <= r_seg;
            end
        end
    end

    crp_ser_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_res   (mul_res)
    );

    crp_pt_store u_store (
        .i_clk   (i_clk),
        .i_we    (accept && i_req.req_type == REQ_WRITE),
        .i_waddr (i_req.point_index[PT_IDX_W-1:0]),
        .i_wdata ({i_req.point_x, i_req.point_y, i_req.point_z}),
        .i_raddr (raddr),
        .o_rdata (rd_pt)
    );

    assign o_valid = r_valid;
    assign o_res   = r_out;

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !(i_req.req_type == REQ_TICK && r_fly)) |=> o_valid)
        else $error("request without flying tick gave no result");

    a_done_ends_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.path_done) |-> (!o_res.in_flight && !r_fly))
        else $error("path done while still flying");

    a_mul_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_INC) |-> (mul_res.busy || mul_res.done))
        else $error("waiting on an idle multiplier");

endmodule

FILE: tb/catmull_rom_path_follower_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_path_follower_test
// Self-checking bench: a directed table, then random phases under several
// rate and point-count settings, each result compared with a spline predictor or a table value.
// ----------------------------------------------------------------------------
module catmull_rom_path_follower_test;
    import crp_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 210;

    typedef struct {
        t_in  req;
        bit   known;
        t_out res;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    logic                o_busy;
    t_in                 i_req = '0;
    logic                o_valid;
    t_out                o_res;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_addr = CFG_RATE;
    logic [CFG_W-1:0]    i_cfg_wdata = '0;

    catmull_rom_path_follower dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    t_point      path_pts [MAX_POINTS];
    logic [16:0] t_now;
    logic [2:0]  seg_now;
    bit          flying;
    logic [15:0] rate_reg;
    logic [3:0]  count_reg;

    t_out        pending_pos [$];
    int          n_errors = 0;
    int          cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("catmull_rom_path_follower verification failed");
            $finish;
        end
    end

    task automatic report(input string what);
        n_errors++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (pending_pos.size() == 0) begin
                report("result with nothing pending");
            end else begin
                want = pending_pos.pop_front();
                if (o_res.pos_x !== want.pos_x)
                    report($sformatf("pos_x %0d want %0d", o_res.pos_x, want.pos_x));
                if (o_res.pos_y !== want.pos_y)
                    report($sformatf("pos_y %0d want %0d", o_res.pos_y, want.pos_y));
                if (o_res.pos_z !== want.pos_z)
                    report($sformatf("pos_z %0d want %0d", o_res.pos_z, want.pos_z));
                if (o_res.in_flight !== want.in_flight)
                    report($sformatf("in_flight %0b want %0b", o_res.in_flight,
                                     want.in_flight));
                if (o_res.path_done !== want.path_done)
                    report($sformatf("path_done %0b want %0b", o_res.path_done,
                                     want.path_done));
                if (o_res.segment_now !== want.segment_now)
                    report($sformatf("segment_now %0d want %0d", o_res.segment_now,
                                     want.segment_now));
            end
        end
    end

    function automatic longint fshift16(input longint v);
        return v >>> 16;
    endfunction

    function automatic logic signed [COORD_W-1:0] spline_coord(input longint q0,
            input longint q1, input longint q2, input longint q3, input longint t);
        longint a0, a1, a2, a3, p;
        a0 = 2 * q1;
        a1 = q2 - q0;
        a2 = 2 * q0 - 5 * q1 + 4 * q2 - q3;
        a3 = -q0 + 3 * q1 - 3 * q2 + q3;
        p = fshift16(a3 * t) + a2;
        p = fshift16(p * t) + a1;
        p = fshift16(p * t) + a0;
        p = (p + 1) >>> 1;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p[COORD_W-1:0];
    endfunction

    function automatic int clip_idx(input int i, input int n);
        return (i > n - 1) ? n - 1 : i;
    endfunction

    // advances the flight state for one accepted request, returns its result
    function automatic t_out follow_path(input t_in r);
        t_out o;
        int n, i, k0, k1, k2, k3;
        longint t;
        o = '0;
        case (r.req_type)
            REQ_WRITE: begin
                path_pts[r.point_index] = '{r.point_x, r.point_y, r.point_z};
            end
            REQ_START: begin
                seg_now = '0;
                t_now = '0;
                flying = 1'b1;
            end
            REQ_TICK: begin
                if (flying) begin
                    n = count_reg < 4 ? 4 :
                        (count_reg > MAX_POINTS ? MAX_POINTS : int'(count_reg));
                    i = int'(seg_now);
                    t = t_now + ((longint'(rate_reg) * longint'(r.tick_dt)) >>> 8);
                    if (t > 65536) t = 65536;
                    t_now = t[16:0];
                    k0 = clip_idx(i == 0 ? 0 : i - 1, n);
                    k1 = clip_idx(i, n);
                    k2 = clip_idx(i + 1, n);
                    k3 = clip_idx(i + 2, n);
                    o.pos_x = spline_coord(path_pts[k0].x, path_pts[k1].x,
                                           path_pts[k2].x, path_pts[k3].x, t);
                    o.pos_y = spline_coord(path_pts[k0].y, path_pts[k1].y,
                                           path_pts[k2].y, path_pts[k3].y, t);
                    o.pos_z = spline_coord(path_pts[k0].z, path_pts[k1].z,
                                           path_pts[k2].z, path_pts[k3].z, t);
                    if (t >= 65536) begin
                        if (i >= n - 3) begin
                            flying = 1'b0;
                            o.path_done = 1'b1;
                        end else begin
                            seg_now = seg_now + 3'd1;
                            t_now = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
        o.in_flight = flying;
        o.segment_now = seg_now;
        return o;
    endfunction

    // leaves start high on return so a back-to-back request follows cleanly
    task automatic issue(input t_in r, input bit known, input t_out res);
        t_out model_res;
        i_start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_busy);
        model_res = follow_path(r);
        if (known) model_res = res;
        pending_pos = {pending_pos, model_res};
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_pos.size() != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RATE) rate_reg = val;
        else count_reg = val[3:0];
        @(posedge i_clk);
    endtask

    function automatic t_in random_req(input bit noise);
        t_in r;
        int pick;
        r.point_index = 3'($urandom_range(0, 7));
        r.point_x = 16'($urandom);
        r.point_y = 16'($urandom);
        r.point_z = 16'($urandom);
        r.tick_dt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 4095)) :
                                                  16'($urandom);
        pick = $urandom_range(0, 99);
        if (noise && pick < 3) r.req_type = REQ_NONE;
        else if (pick < 15) r.req_type = REQ_WRITE;
        else if (pick < 25) r.req_type = REQ_START;
        else r.req_type = REQ_TICK;
        return r;
    endfunction

    function automatic t_in mk(input t_req_type k, input int idx, input int x,
                               input int y, input int z, input int dt);
        t_in r;
        r.req_type = k;
        r.point_index = 3'(idx);
        r.point_x = 16'(x);
        r.point_y = 16'(y);
        r.point_z = 16'(z);
        r.tick_dt = 16'(dt);
        return r;
    endfunction

    function automatic t_out idle_res(input bit fl);
        t_out o;
        o = '0;
        o.in_flight = fl;
        return o;
    endfunction

    t_row directed [$];
    logic [15:0] rate_plan [N_PHASES] = '{16'd0, 16'hFFFF, 16'd256, 16'd1, 16'd4096,
                                          16'd777, 16'hFFFF, 16'd300};
    logic [15:0] count_plan [N_PHASES] = '{16'd4, 16'd8, 16'd15, 16'd0, 16'd5,
                                           16'hFFF7, 16'd6, 16'd8};

    task automatic add_row(input t_in req, input bit known, input t_out res);
        t_row row;
        row.req = req;
        row.known = known;
        row.res = res;
        directed = {directed, row};
    endtask

    initial begin
        int gap;
        int total;
        t_in r;
        for (int k = 0; k < MAX_POINTS; k++) path_pts[k] = '0;
        t_now = '0;
        seg_now = '0;
        flying = 1'b0;
        rate_reg = RATE_RST;
        count_reg = CNT_RST;

        // every slot written before any flight, with the coordinate extremes
        add_row(mk(REQ_WRITE, 0, 32767, -32768, 0, 0), 1, idle_res(0));
        add_row(mk(REQ_WRITE, 1, -32768, 32767, -1, 0), 1, idle_res(0));
        add_row(mk(REQ_WRITE, 2, 32767, -32768, 32767, 0), 1, idle_res(0));
        add_row(mk(REQ_WRITE, 3, -32768, 32767, -32768, 65535), 1, idle_res(0));
        add_row(mk(REQ_WRITE, 4, 256, 512, -256, 0), 1, idle_res(0));
        add_row(mk(REQ_WRITE, 5, 1024, -1024, 0, 0), 1, idle_res(0));
        add_row(mk(REQ_WRITE, 6, -1, 1, 100, 0), 1, idle_res(0));
        add_row(mk(REQ_WRITE, 7, 0, 0, 0, 0), 1, idle_res(0));
        add_row(mk(REQ_NONE, 7, -1, -1, -1, 65535), 1, idle_res(0));
        add_row(mk(REQ_TICK, 0, 0, 0, 0, 65535), 1, idle_res(0));
        add_row(mk(REQ_START, 0, 0, 0, 0, 0), 1, idle_res(1));
        add_row(mk(REQ_TICK, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(REQ_TICK, 0, 0, 0, 0, 16384), 0, '0);
        add_row(mk(REQ_WRITE, 5, 2048, 0, -2048, 0), 0, '0);
        add_row(mk(REQ_NONE, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(REQ_TICK, 0, 0, 0, 0, 65535), 0, '0);
        add_row(mk(REQ_TICK, 0, 0, 0, 0, 65535), 0, '0);
        add_row(mk(REQ_START, 0, 0, 0, 0, 0), 1, idle_res(1));
        for (int k = 0; k < 6; k++)
            add_row(mk(REQ_TICK, 0, 0, 0, 0, 65535), 0, '0);
        add_row(mk(REQ_TICK, 0, 0, 0, 0, 65535), 0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) issue(directed[k].req, directed[k].known, directed[k].res);
        wait_drained();

        total = 0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_reg(CFG_RATE, ph == 7 ? 16'($urandom) : rate_plan[ph]);
            write_reg(CFG_COUNT, count_plan[ph]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = random_req(1);
                issue(r, 0, '0);
                total++;
                if (total == 600) wait_drained();
                if (total < N_PHASES * PHASE_ITEMS - 200 && $urandom_range(0, 5) == 0) begin
                    gap = $urandom_range(1, 11);
                    i_start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            wait_drained();
        end

        repeat (400) @(posedge i_clk);
        if (n_errors == 0)
            $display("catmull_rom_path_follower verification clean");
        else
            $display("catmull_rom_path_follower verification failed");
        $finish;
    end

endmodule
